// ===== rtl/vang_pkg.sv =====
// Shared types and constants of the 3D vector angle block.
`timescale 1ns / 1ps
package vang_pkg;

	// Angles in units of 2^-30 rad.
	localparam logic [31:0] ANG_HALF_PI = 32'd1686629713;
	localparam logic [31:0] ANG_PI      = 32'd3373259426;
	// 180/pi scaled by 2^24.
	localparam logic [29:0] DEG_SCALE   = 30'd961263669;

	localparam int ISQRT_STEPS  = 32;
	localparam int CORDIC_STEPS = 31;

	localparam logic [29:0] ATAN_TAB [10] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
	};

	// Fixed-point atan(2^-i); past the table it is 2^(30-i).
	function automatic logic [29:0] atan_val(input int i);
		logic [29:0] r;
		if (i < 10) r = ATAN_TAB[i];
		else r = 30'(1) << (30 - i);
		return r;
	endfunction

	typedef struct packed {
		logic neg;
		logic zero;
	} vang_tag_t;

	// One request handed from the front part to the back part.
	typedef struct packed {
		logic [31:0] x0;
		logic [63:0] rad;
		vang_tag_t   tag;
	} vang_item_t;

	typedef struct packed {
		logic [15:0] angle;
		logic        zero_length;
	} vang_res_t;

endpackage

// ===== rtl/vector_angle_3d.sv =====
// Top level of the 3D vector angle block.
//
//  channel   direction  handshake       payload
//  input     in         push / full     a_x a_y a_z b_x b_y b_z
//  result    out        pop / empty     angle zero_length
//  config    in         cfg_wen         cfg_wdata (angle_unit)
//
// One request is accepted per cycle, sustained, while the handoff queue is not full.
// A request passes seven front stages (the first loads at the accepting edge), the
// handoff queue, 32 square-root stages, 31 CORDIC stages, three conversion stages
// and the result queue. No clearing pass follows reset.
// The front stalls only when the handoff queue is full; the back stalls only
// when the result queue is full.
`timescale 1ns / 1ps
module vector_angle_3d #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic                          pop,
	output logic                          empty,
	output logic [15:0]                   angle,
	output logic                          zero_length,
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata
);
	import vang_pkg::*;

	logic       angle_unit_q;
	logic       en_front, en_back;
	logic       fr_valid, mid_full, mid_empty, mid_pop;
	vang_item_t fr_item, mid_item;
	logic       bk_valid, res_full;
	vang_res_t  bk_res, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) angle_unit_q <= 1'b0;
		else if (cfg_wen) angle_unit_q <= cfg_wdata;
	end

	assign en_front = !mid_full;
	assign full     = mid_full;
	assign en_back  = !res_full;
	assign mid_pop  = en_back && !mid_empty;

	vang_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_front),
		.in_valid  (push),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.out_valid (fr_valid),
		.out_item  (fr_item)
	);

	vang_fifo #(
		.WIDTH ($bits(vang_item_t)),
		.DEPTH (4)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en_front && fr_valid),
		.wdata  (fr_item),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	vang_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_back),
		.angle_unit (angle_unit_q),
		.in_valid   (mid_pop),
		.in_item    (mid_item),
		.out_valid  (bk_valid),
		.out_res    (bk_res)
	);

	vang_fifo #(
		.WIDTH ($bits(vang_res_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en_back && bk_valid),
		.wdata  (bk_res),
		.pop    (pop),
		.rdata  (res_out),
		.full   (res_full),
		.empty  (empty)
	);

	assign angle       = res_out.angle;
	assign zero_length = res_out.zero_length;
endmodule

// ===== rtl/vang_fifo.sv =====
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps
module vang_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end
endmodule

// ===== rtl/vang_front.sv =====
// Front part: input capture, zero check, scaling, products and pre-normalization.
`timescale 1ns / 1ps
module vang_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	output logic                          out_valid,
	output vang_pkg::vang_item_t          out_item
);
	import vang_pkg::*;

	localparam int EW = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
	localparam int LW = $clog2(EW + 1);

	// Right shift that brings the largest magnitude below 2^15.
	function automatic logic [LW-1:0] fit_shift(input logic signed [EW-1:0] c0,
			input logic signed [EW-1:0] c1, input logic signed [EW-1:0] c2);
		logic [EW-1:0] m0, m1, m2, m;
		logic [LW-1:0] len;
		m0 = c0[EW-1] ? EW'(-c0) : EW'(c0);
		m1 = c1[EW-1] ? EW'(-c1) : EW'(c1);
		m2 = c2[EW-1] ? EW'(-c2) : EW'(c2);
		m = m0;
		if (m1 > m) m = m1;
		if (m2 > m) m = m2;
		len = '0;
		for (int i = 0; i < EW; i++) begin
			if (m[i]) len = LW'(i + 1);
		end
		return (len > LW'(15)) ? len - LW'(15) : '0;
	endfunction

	logic [7:1] vld;

	// Stage 1: extended inputs.
	logic signed [EW-1:0] a_s1 [3];
	logic signed [EW-1:0] b_s1 [3];
	logic                 zero_s1;
	// Stage 2: components scaled to 16 bits.
	logic signed [15:0]   a_s2 [3];
	logic signed [15:0]   b_s2 [3];
	logic                 zero_s2;
	// Stage 3: products.
	logic signed [31:0]   pd_s3 [3];
	logic [31:0]          qa_s3 [3];
	logic [31:0]          qb_s3 [3];
	logic                 zero_s3;
	// Stage 4: sums.
	logic signed [33:0]   d_s4;
	logic [31:0]          na_s4, nb_s4;
	logic                 zero_s4;
	// Stage 5: wide products.
	logic [63:0]          p_s5, md2_s5;
	logic [31:0]          md_s5;
	logic                 neg_s5, zero_s5;
	// Stage 6: cross term and normalizing shift.
	logic [63:0]          c2_s6;
	logic [4:0]           k_s6;
	logic [31:0]          md_s6;
	logic                 neg_s6, zero_s6;
	// Stage 7: request for the back part.
	vang_item_t           item_s7;

	logic [LW-1:0]        sa, sb;
	logic [5:0]           lz;
	logic [31:0]          md;

	assign sa = fit_shift(a_s1[0], a_s1[1], a_s1[2]);
	assign sb = fit_shift(b_s1[0], b_s1[1], b_s1[2]);
	assign md = d_s4[33] ? 32'(-d_s4) : 32'(d_s4);

	always_comb begin
		lz = 6'd63;
		for (int i = 0; i < 64; i++) begin
			if (p_s5[i]) lz = 6'(63 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else if (en) vld <= {vld[6:1], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= EW'(a_x);
			a_s1[1] <= EW'(a_y);
			a_s1[2] <= EW'(a_z);
			b_s1[0] <= EW'(b_x);
			b_s1[1] <= EW'(b_y);
			b_s1[2] <= EW'(b_z);
			zero_s1 <= (a_x == '0 && a_y == '0 && a_z == '0) ||
				(b_x == '0 && b_y == '0 && b_z == '0);

			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= 16'(a_s1[i] >>> sa);
				b_s2[i] <= 16'(b_s1[i] >>> sb);
			end
			zero_s2 <= zero_s1;

			for (int i = 0; i < 3; i++) begin
				pd_s3[i] <= 32'(a_s2[i] * b_s2[i]);
				qa_s3[i] <= 32'(a_s2[i] * a_s2[i]);
				qb_s3[i] <= 32'(b_s2[i] * b_s2[i]);
			end
			zero_s3 <= zero_s2;

			d_s4    <= 34'(pd_s3[0]) + 34'(pd_s3[1]) + 34'(pd_s3[2]);
			na_s4   <= qa_s3[0] + qa_s3[1] + qa_s3[2];
			nb_s4   <= qb_s3[0] + qb_s3[1] + qb_s3[2];
			zero_s4 <= zero_s3;

			p_s5    <= 64'(na_s4) * 64'(nb_s4);
			md2_s5  <= 64'(md) * 64'(md);
			md_s5   <= md;
			neg_s5  <= d_s4[33];
			zero_s5 <= zero_s4;

			c2_s6   <= p_s5 - md2_s5;
			k_s6    <= lz[5:1];
			md_s6   <= md_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;

			item_s7.x0       <= md_s6 << k_s6;
			item_s7.rad      <= c2_s6 << {k_s6, 1'b0};
			item_s7.tag.neg  <= neg_s6;
			item_s7.tag.zero <= zero_s6;
		end
	end

	assign out_valid = vld[7];
	assign out_item  = item_s7;
endmodule

// ===== rtl/vang_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module vang_isqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  vang_pkg::vang_item_t in_item,
	output logic                 out_valid,
	output logic [31:0]          out_x,
	output logic [31:0]          out_y,
	output vang_pkg::vang_tag_t  out_tag
);
	import vang_pkg::*;

	logic [63:0] rem_s  [1:ISQRT_STEPS];
	logic [63:0] root_s [1:ISQRT_STEPS];
	logic [31:0] x_s    [1:ISQRT_STEPS];
	vang_tag_t   tag_s  [1:ISQRT_STEPS];
	logic        vld_s  [1:ISQRT_STEPS];

	for (genvar n = 0; n < ISQRT_STEPS; n++) begin : g_step
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * n);
		logic [63:0] rem_in, root_in, trial;
		logic [31:0] x_in;
		vang_tag_t   tag_in;
		logic        vld_in;

		if (n == 0) begin : g_first
			assign rem_in  = in_item.rad;
			assign root_in = '0;
			assign x_in    = in_item.x0;
			assign tag_in  = in_item.tag;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[n];
			assign root_in = root_s[n];
			assign x_in    = x_s[n];
			assign tag_in  = tag_s[n];
			assign vld_in  = vld_s[n];
		end

		assign trial = root_in + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[n+1] <= 1'b0;
			else if (en) vld_s[n+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[n+1]  <= rem_in - trial;
					root_s[n+1] <= (root_in >> 1) + BITV;
				end else begin
					rem_s[n+1]  <= rem_in;
					root_s[n+1] <= root_in >> 1;
				end
				x_s[n+1]   <= x_in;
				tag_s[n+1] <= tag_in;
			end
		end
	end

	assign out_valid = vld_s[ISQRT_STEPS];
	assign out_x     = x_s[ISQRT_STEPS];
	assign out_y     = root_s[ISQRT_STEPS][31:0];
	assign out_tag   = tag_s[ISQRT_STEPS];
endmodule

// ===== rtl/vang_cordic.sv =====
// Pipelined vectoring CORDIC, one rotation per stage.
`timescale 1ns / 1ps
module vang_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         in_x,
	input  logic [31:0]         in_y,
	input  vang_pkg::vang_tag_t in_tag,
	output logic                out_valid,
	output logic signed [33:0]  out_z,
	output vang_pkg::vang_tag_t out_tag
);
	import vang_pkg::*;

	logic signed [35:0] x_s   [1:CORDIC_STEPS];
	logic signed [35:0] y_s   [1:CORDIC_STEPS];
	logic signed [33:0] z_s   [1:CORDIC_STEPS];
	vang_tag_t          tag_s [1:CORDIC_STEPS];
	logic               vld_s [1:CORDIC_STEPS];

	for (genvar n = 0; n < CORDIC_STEPS; n++) begin : g_step
		localparam logic signed [33:0] ANG = 34'(atan_val(n));
		logic signed [35:0] x_in, y_in, dx, dy;
		logic signed [33:0] z_in;
		vang_tag_t          tag_in;
		logic               vld_in;

		if (n == 0) begin : g_first
			assign x_in   = 36'(in_x);
			assign y_in   = 36'(in_y);
			assign z_in   = '0;
			assign tag_in = in_tag;
			assign vld_in = in_valid;
		end else begin : g_next
			assign x_in   = x_s[n];
			assign y_in   = y_s[n];
			assign z_in   = z_s[n];
			assign tag_in = tag_s[n];
			assign vld_in = vld_s[n];
		end

		assign dx = y_in >>> n;
		assign dy = x_in >>> n;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[n+1] <= 1'b0;
			else if (en) vld_s[n+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_in[35]) begin
					x_s[n+1] <= x_in + dx;
					y_s[n+1] <= y_in - dy;
					z_s[n+1] <= z_in + ANG;
				end else begin
					x_s[n+1] <= x_in - dx;
					y_s[n+1] <= y_in + dy;
					z_s[n+1] <= z_in - ANG;
				end
				tag_s[n+1] <= tag_in;
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS];
	assign out_z     = z_s[CORDIC_STEPS];
	assign out_tag   = tag_s[CORDIC_STEPS];
endmodule

// ===== rtl/vang_back.sv =====
// Back part: square root, CORDIC, quadrant fix-up and unit conversion.
`timescale 1ns / 1ps
module vang_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 angle_unit,
	input  logic                 in_valid,
	input  vang_pkg::vang_item_t in_item,
	output logic                 out_valid,
	output vang_pkg::vang_res_t  out_res
);
	import vang_pkg::*;

	logic               sq_valid, cd_valid;
	logic [31:0]        sq_x, sq_y;
	vang_tag_t          sq_tag, cd_tag;
	logic signed [33:0] cd_z;

	logic [31:0]        zc;
	logic [31:0]        z_s1;
	logic               zero_s1;
	logic [61:0]        deg_s2;
	logic [15:0]        rad_s2;
	logic               zero_s2;
	logic [62:0]        deg_round;
	vang_res_t          res_s3;
	logic [3:1]         vld;

	vang_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_valid (sq_valid),
		.out_x     (sq_x),
		.out_y     (sq_y),
		.out_tag   (sq_tag)
	);

	vang_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_x      (sq_x),
		.in_y      (sq_y),
		.in_tag    (sq_tag),
		.out_valid (cd_valid),
		.out_z     (cd_z),
		.out_tag   (cd_tag)
	);

	always_comb begin
		if (cd_z[33]) zc = '0;
		else if (cd_z > 34'(ANG_HALF_PI)) zc = ANG_HALF_PI;
		else zc = cd_z[31:0];
	end

	assign deg_round = 63'(deg_s2) + (63'(1) << 45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else if (en) vld <= {vld[2:1], cd_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// A negative dot product puts the angle in the second quadrant.
			z_s1    <= cd_tag.neg ? ANG_PI - zc : zc;
			zero_s1 <= cd_tag.zero;

			deg_s2  <= 62'(z_s1) * 62'(DEG_SCALE);
			rad_s2  <= 16'((33'(z_s1) + 33'(32768)) >> 16);
			zero_s2 <= zero_s1;

			if (zero_s2) res_s3.angle <= '0;
			else if (angle_unit) res_s3.angle <= deg_round[61:46];
			else res_s3.angle <= rad_s2;
			res_s3.zero_length <= zero_s2;
		end
	end

	assign out_valid = vld[3];
	assign out_res   = res_s3;
endmodule
